// ----- rtl/chip8_instruction_core_top_defines.svh -----
// Assertion macros for the CHIP-8 core RTL.
// No dependencies.
`ifndef CHIP8_INSTRUCTION_CORE_TOP_DEFINES_SVH
`define CHIP8_INSTRUCTION_CORE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define C8_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define C8_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define C8_ASSERT_IMPL(label, clk, rst, ante, cons)
`define C8_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/c8core_pkg.sv -----
// Shared types, constants and the hex font for the CHIP-8 core.
// No dependencies.
`default_nettype none
package c8core_pkg;
   localparam int MemoryBytes   = 4096;
   localparam int AddrBits      = 12;
   localparam int ScreenColumns = 64;
   localparam int ScreenRows    = 32;
   localparam int Pixels        = ScreenColumns * ScreenRows;
   localparam int PixBits       = 11;
   localparam int StackDepth    = 16;
   localparam int SpBits        = 4;
   localparam int FontBase      = 80;
   localparam int FontLen       = 80;
   localparam logic [11:0] StartReset = 12'h200;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0, OP_KEY = 2'd1, OP_EXEC = 2'd2, OP_PIXEL = 2'd3
   } op_type;

   // memory port select codes; the datapath does not use this type
   typedef enum logic [2:0] {
      MA_PC, MA_PC1, MA_IDX, MA_REQ, MA_CLR
   } maddr_type;

   typedef enum logic [3:0] {
      DC_NONE, DC_LATCH, DC_FETCH_HI, DC_FETCH_LO, DC_EXEC, DC_CLEAR,
      DC_SPRITE_ROW, DC_SPRITE_PIX, DC_BCD, DC_STORE, DC_LOAD, DC_TIMERS,
      DC_PIXEL, DC_PIXWB, DC_LOADWB
   } dcmd_type;

   typedef struct packed {
      dcmd_type  cmd;
      logic [3:0] step;      // row / register / digit counter
      logic [2:0] bit_idx;   // sprite column
      logic [10:0] clr_addr;
   } ctl_type;

   typedef struct packed {
      logic [15:0] opcode;
      logic [3:0]  nx;
      logic [3:0]  n;
      logic        is_clear;
      logic        is_draw;
      logic        is_bcd;
      logic        is_store;
      logic        is_load;
   } stat_type;

   function automatic logic [7:0] font_byte(input logic [6:0] i);
      logic [7:0] f [0:79];
      f = '{8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
            8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
            8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
            8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
            8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
            8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
            8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
            8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};
      font_byte = (i < 7'd80) ? f[i] : 8'h00;
   endfunction
endpackage
`default_nettype wire

// ----- rtl/c8core_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module c8core_ram #(
   parameter int Width = 8,
   parameter int Depth = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wdata,
   output logic      [Width-1:0]         rdata
);
   logic [Width-1:0] mem_ff [0:Depth-1];
   always_ff @(posedge clock) begin
      if (we) mem_ff[addr] <= wdata;
      rdata <= mem_ff[addr];
   end
endmodule
`default_nettype wire

// ----- rtl/c8core_datapath.sv -----
// CHIP-8 datapath: memory, frame store, registers, stack, timers.
// Depends on c8core_pkg and c8core_ram.
`default_nettype none
module c8core_datapath (
   input  wire logic clock,
   input  wire logic reset,
   input  wire c8core_pkg::ctl_type ctl,
   input  wire logic        init_busy,
   input  wire logic [11:0] init_addr,
   input  wire logic        csr_we,
   input  wire logic [11:0] csr_data,
   input  wire logic [1:0]  req_operation,
   input  wire logic [11:0] req_address,
   input  wire logic [7:0]  req_data,
   input  wire logic [3:0]  req_key_index,
   input  wire logic        req_key_down,
   input  wire logic [7:0]  req_random_byte,
   output c8core_pkg::stat_type stat,
   output logic [11:0] rsp_program_counter,
   output logic [15:0] rsp_opcode,
   output logic        rsp_draw_flag,
   output logic        rsp_sound_beep,
   output logic        rsp_invalid_opcode,
   output logic        rsp_waiting_for_key,
   output logic        rsp_pixel
);
   import c8core_pkg::*;

   logic [11:0] start_ff, pc_ff, here_ff;
   logic [15:0] idx_ff, opc_ff;
   logic [7:0]  v_ff [0:15];
   logic [11:0] stk_ff [0:StackDepth-1];
   logic [SpBits-1:0] sp_ff;
   logic [7:0]  dt_ff, st_ff;
   logic [15:0] keys_ff;
   logic        beep_ff, bad_ff, wait_ff, draw_ff, pix_ff;
   logic [1:0]  op_ff;
   logic [11:0] addr_ff;
   logic [7:0]  rnd_ff;
   logic [7:0]  sprite_ff;
   logic [7:0]  spr_x_ff, spr_y_ff;
   logic [7:0]  bcd_ff [0:2];

   // main memory port
   logic        m_we;
   logic [11:0] m_addr;
   logic [7:0]  m_wd, m_rd;
   // frame store port
   logic        f_we;
   logic [10:0] f_addr;
   logic        f_wd, f_rd;

   c8core_ram #(.Width(8), .Depth(MemoryBytes)) u_mem (
      .clock(clock), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd));
   c8core_ram #(.Width(1), .Depth(Pixels)) u_frame (
      .clock(clock), .we(f_we), .addr(f_addr), .wdata(f_wd), .rdata(f_rd));

   logic [3:0] x, y, n;
   logic [7:0] nn, vx, vy;
   logic [11:0] nnn;
   assign x = opc_ff[11:8];
   assign y = opc_ff[7:4];
   assign n = opc_ff[3:0];
   assign nn = opc_ff[7:0];
   assign nnn = opc_ff[11:0];
   assign vx = v_ff[x];
   assign vy = v_ff[y];

   // sprite pixel location, from VX/VY as they were before VF was cleared
   logic [4:0] srow;
   logic [5:0] scol;
   assign srow = 5'(spr_y_ff + 8'(ctl.step));
   assign scol = 6'(spr_x_ff + 8'(ctl.bit_idx));

   logic font_hit;
   assign font_hit = (init_addr >= 12'(FontBase)) && (init_addr < 12'(FontBase + FontLen));

   always_comb begin
      m_we = 1'b0; m_addr = pc_ff; m_wd = 8'h00;
      f_we = 1'b0; f_addr = 11'({srow, scol}); f_wd = 1'b0;
      if (init_busy) begin
         m_we = 1'b1; m_addr = init_addr;
         m_wd = font_hit ? font_byte(7'(init_addr - 12'(FontBase))) : 8'h00;
         f_we = init_addr < 12'(Pixels); f_addr = init_addr[10:0];
      end else begin
         unique case (ctl.cmd)
            DC_LATCH: begin
               m_we = (req_operation == OP_WRITE); m_wd = req_data;
               // an execute starts its fetch here
               m_addr = (req_operation == OP_WRITE) ? req_address : pc_ff;
               f_addr = req_address[10:0];
            end
            DC_FETCH_HI: m_addr = 12'(pc_ff + 12'd1);
            DC_CLEAR: begin
               f_we = 1'b1; f_addr = ctl.clr_addr;
            end
            DC_SPRITE_ROW: m_addr = 12'(idx_ff + 16'(ctl.step));
            DC_BCD: begin
               m_we = 1'b1; m_addr = 12'(idx_ff + 16'(ctl.step));
               m_wd = bcd_ff[ctl.step[1:0]];
            end
            DC_STORE: begin
               m_we = 1'b1; m_addr = 12'(idx_ff + 16'(ctl.step)); m_wd = v_ff[ctl.step];
            end
            DC_LOAD: m_addr = 12'(idx_ff + 16'(ctl.step));
            DC_PIXWB: begin
               f_we = sprite_ff[3'd7 - ctl.bit_idx];
               f_wd = ~f_rd;
            end
            default: ;
         endcase
      end
   end

   // sprite pixel RMW: read in SPRITE_PIX, write back in the PIXWB slot
   // (the controller alternates SPRITE_PIX / PIXWB while drawing)
   logic        key_any;
   logic [3:0]  key_low;
   always_comb begin
      key_any = |keys_ff;
      key_low = 4'd0;
      for (int k = 15; k >= 0; k--)
         if (keys_ff[k]) key_low = 4'(k);
   end

   logic [8:0] sum9;
   assign sum9 = {1'b0, vx} + {1'b0, vy};

   // FX33 digits: compare-subtract for hundreds, reciprocal multiply for tens
   logic [1:0]  bcd_h;
   logic [6:0]  bcd_r;
   logic [14:0] bcd_p;
   logic [3:0]  bcd_t, bcd_o;
   always_comb begin
      if (vx >= 8'd200) begin
         bcd_h = 2'd2; bcd_r = 7'(vx - 8'd200);
      end else if (vx >= 8'd100) begin
         bcd_h = 2'd1; bcd_r = 7'(vx - 8'd100);
      end else begin
         bcd_h = 2'd0; bcd_r = vx[6:0];
      end
      bcd_p = 15'(bcd_r) * 15'd205;
      bcd_t = bcd_p[14:11];
      bcd_o = 4'(bcd_r - 7'(bcd_t) * 7'd10);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= StartReset; pc_ff <= StartReset; idx_ff <= '0; sp_ff <= '0;
         dt_ff <= '0; st_ff <= '0; keys_ff <= '0;
         for (int k = 0; k < 16; k++) v_ff[k] <= '0;
         for (int k = 0; k < StackDepth; k++) stk_ff[k] <= '0;
      end else begin
         if (csr_we) begin
            start_ff <= csr_data; pc_ff <= csr_data;
         end
         unique case (ctl.cmd)
            DC_LATCH: begin
               op_ff <= req_operation; addr_ff <= req_address;
               rnd_ff <= req_random_byte;
               opc_ff <= '0; draw_ff <= 1'b0; beep_ff <= 1'b0;
               bad_ff <= 1'b0; wait_ff <= 1'b0;
               here_ff <= pc_ff;
               if (req_operation == OP_KEY) keys_ff[req_key_index] <= req_key_down;
            end
            DC_FETCH_HI: opc_ff[15:8] <= m_rd;
            DC_FETCH_LO: begin
               opc_ff[7:0] <= m_rd;
               pc_ff <= (13'(pc_ff) + 13'd2 >= 13'h0FFF) ? start_ff : 12'(pc_ff + 12'd2);
            end
            DC_EXEC: begin
               spr_x_ff <= vx; spr_y_ff <= vy;
               priority case (opc_ff[15:12])
                  4'h0: begin
                     if (nnn == 12'h0E0) draw_ff <= 1'b1;
                     else if (nnn == 12'h0EE) begin
                        sp_ff <= sp_ff - 1'b1; pc_ff <= stk_ff[sp_ff - 1'b1];
                     end else bad_ff <= 1'b1;
                  end
                  4'h1: pc_ff <= nnn;
                  4'h2: begin
                     stk_ff[sp_ff] <= pc_ff; sp_ff <= sp_ff + 1'b1; pc_ff <= nnn;
                  end
                  4'h3: if (vx == nn) pc_ff <= pc_ff + 12'd2;
                  4'h4: if (vx != nn) pc_ff <= pc_ff + 12'd2;
                  4'h5: if (vx == vy) pc_ff <= pc_ff + 12'd2;
                  4'h6: v_ff[x] <= nn;
                  4'h7: v_ff[x] <= vx + nn;
                  4'h8: begin
                     unique case (n)
                        4'h0: v_ff[x] <= vy;
                        4'h1: v_ff[x] <= vx | vy;
                        4'h2: v_ff[x] <= vx & vy;
                        4'h3: v_ff[x] <= vx ^ vy;
                        4'h4: begin v_ff[x] <= sum9[7:0]; v_ff[15] <= {7'd0, sum9[8]}; end
                        4'h5: begin v_ff[x] <= vx - vy; v_ff[15] <= {7'd0, vx >= vy}; end
                        4'h6: begin v_ff[x] <= vx >> 1; v_ff[15] <= {7'd0, vx[0]}; end
                        4'h7: begin v_ff[x] <= vy - vx; v_ff[15] <= {7'd0, vy >= vx}; end
                        4'hE: begin v_ff[x] <= vx << 1; v_ff[15] <= {7'd0, vx[7]}; end
                        default: bad_ff <= 1'b1;
                     endcase
                  end
                  4'h9: if (vx != vy) pc_ff <= pc_ff + 12'd2;
                  4'hA: idx_ff <= {4'd0, nnn};
                  4'hB: pc_ff <= 12'(nnn + 12'(v_ff[0]));
                  4'hC: v_ff[x] <= rnd_ff & nn;
                  4'hD: begin v_ff[15] <= 8'd0; draw_ff <= 1'b1; end
                  4'hE: begin
                     if (nn == 8'h9E) begin
                        if (keys_ff[vx[3:0]]) pc_ff <= pc_ff + 12'd2;
                     end else if (nn == 8'hA1) begin
                        if (!keys_ff[vx[3:0]]) pc_ff <= pc_ff + 12'd2;
                     end else bad_ff <= 1'b1;
                  end
                  default: begin
                     unique case (nn)
                        8'h07: v_ff[x] <= dt_ff;
                        8'h0A: if (key_any) v_ff[x] <= {4'd0, key_low};
                               else begin wait_ff <= 1'b1; pc_ff <= here_ff; end
                        8'h15: dt_ff <= vx;
                        8'h18: st_ff <= vx;
                        8'h1E: idx_ff <= idx_ff + 16'(vx);
                        8'h29: idx_ff <= 16'(FontBase) + 16'(vx) * 16'd5;
                        8'h33: begin
                           bcd_ff[0] <= {6'd0, bcd_h};
                           bcd_ff[1] <= {4'd0, bcd_t};
                           bcd_ff[2] <= {4'd0, bcd_o};
                        end
                        8'h55, 8'h65: ;
                        default: bad_ff <= 1'b1;
                     endcase
                  end
               endcase
            end
            DC_SPRITE_ROW: ;
            DC_SPRITE_PIX: if (ctl.bit_idx == 3'd0) sprite_ff <= m_rd;
            DC_LOAD: ;
            DC_PIXWB: if (sprite_ff[3'd7 - ctl.bit_idx] && f_rd) v_ff[15] <= 8'd1;
            DC_LOADWB: v_ff[ctl.step] <= m_rd;
            DC_TIMERS: begin
               if (dt_ff != 8'd0) dt_ff <= dt_ff - 8'd1;
               if (st_ff != 8'd0) st_ff <= st_ff - 8'd1;
               beep_ff <= (st_ff == 8'd1);
            end
            DC_PIXEL: pix_ff <= (addr_ff < 12'(Pixels)) ? f_rd : 1'b0;
            default: ;
         endcase
      end
   end

   assign stat.opcode   = opc_ff;
   assign stat.nx       = x;
   assign stat.n        = n;
   assign stat.is_clear = (opc_ff == 16'h00E0);
   assign stat.is_draw  = (opc_ff[15:12] == 4'hD);
   assign stat.is_bcd   = (opc_ff[15:12] == 4'hF) && (nn == 8'h33);
   assign stat.is_store = (opc_ff[15:12] == 4'hF) && (nn == 8'h55);
   assign stat.is_load  = (opc_ff[15:12] == 4'hF) && (nn == 8'h65);

   logic is_exec;
   assign is_exec = (op_ff == OP_EXEC);
   assign rsp_program_counter = pc_ff;
   assign rsp_opcode          = is_exec ? opc_ff : 16'd0;
   assign rsp_draw_flag       = is_exec & draw_ff;
   assign rsp_sound_beep      = is_exec & beep_ff;
   assign rsp_invalid_opcode  = is_exec & bad_ff;
   assign rsp_waiting_for_key = is_exec & wait_ff;
   assign rsp_pixel           = (op_ff == OP_PIXEL) & pix_ff;
endmodule
`default_nettype wire

// ----- rtl/c8core_ctrl.sv -----
// CHIP-8 sequencer: walks each request through fetch, execute and the
// multi-cycle sweeps. Depends on c8core_pkg and the defines header.
`default_nettype none
`include "chip8_instruction_core_top_defines.svh"
module c8core_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [1:0] req_operation,
   input  wire c8core_pkg::stat_type stat,
   output c8core_pkg::ctl_type ctl,
   output logic busy,
   output logic init_busy,
   output logic [11:0] init_addr,
   output logic rsp_valid
);
   import c8core_pkg::*;

   typedef enum logic [10:0] {
      S_INIT   = 11'b00000000001,
      S_IDLE   = 11'b00000000010,
      S_FHI    = 11'b00000000100,
      S_FLO    = 11'b00000001000,
      S_EXEC   = 11'b00000010000,
      S_CLEAR  = 11'b00000100000,
      S_ROW    = 11'b00001000000,
      S_PIX    = 11'b00010000000,
      S_PIXWB  = 11'b00100000000,
      S_SEQ    = 11'b01000000000,
      S_DONE   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic [12:0] init_ff, init_in;
   logic [3:0]  step_ff, step_in;
   logic [2:0]  bit_ff, bit_in;
   logic [10:0] clr_ff, clr_in;
   logic [1:0]  op_ff, op_in;
   logic        rv_ff, rv_in;
   logic        tim_ff, tim_in;   // sweep finished, timers next

   assign busy      = (state_ff != S_IDLE);
   assign init_busy = (state_ff == S_INIT);
   assign init_addr = init_ff[11:0];
   assign rsp_valid = rv_ff;

   always_comb begin
      state_in = state_ff; init_in = init_ff; step_in = step_ff; bit_in = bit_ff;
      clr_in = clr_ff; op_in = op_ff; rv_in = 1'b0; tim_in = tim_ff;
      ctl.cmd = DC_NONE; ctl.step = step_ff; ctl.bit_idx = bit_ff; ctl.clr_addr = clr_ff;
      unique case (state_ff)
         S_INIT: begin
            init_in = init_ff + 13'd1;
            if (init_ff == 13'(MemoryBytes - 1)) state_in = S_IDLE;
         end
         S_IDLE: if (start) begin
            ctl.cmd = DC_LATCH; op_in = req_operation; tim_in = 1'b0;
            unique case (req_operation)
               OP_EXEC:  state_in = S_FHI;
               OP_PIXEL: state_in = S_SEQ;
               default:  state_in = S_DONE;
            endcase
         end
         S_FHI: begin ctl.cmd = DC_FETCH_HI; state_in = S_FLO; end
         S_FLO: begin ctl.cmd = DC_FETCH_LO; state_in = S_EXEC; end
         S_EXEC: begin
            ctl.cmd = DC_EXEC; step_in = '0; bit_in = '0; clr_in = '0;
            if (stat.is_clear) state_in = S_CLEAR;
            else if (stat.is_draw) state_in = (stat.n == 4'd0) ? S_SEQ : S_ROW;
            else state_in = S_SEQ;
         end
         S_CLEAR: begin
            ctl.cmd = DC_CLEAR; clr_in = clr_ff + 11'd1;
            if (clr_ff == 11'(Pixels - 1)) state_in = S_SEQ;
         end
         S_ROW: begin ctl.cmd = DC_SPRITE_ROW; bit_in = '0; state_in = S_PIX; end
         S_PIX: begin ctl.cmd = DC_SPRITE_PIX; state_in = S_PIXWB; end
         S_PIXWB: begin
            ctl.cmd = DC_PIXWB;
            bit_in = bit_ff + 3'd1;
            if (bit_ff == 3'd7) begin
               step_in = step_ff + 4'd1;
               state_in = (step_ff + 4'd1 == stat.n) ? S_SEQ : S_ROW;
               if (step_ff + 4'd1 == stat.n) step_in = '0;
            end else state_in = S_PIX;
         end
         S_SEQ: begin
            // BCD/store/load sweeps, then timers; pixel read for op 3
            if (op_ff == OP_PIXEL) begin
               ctl.cmd = DC_PIXEL; state_in = S_DONE;
            end else if (stat.is_bcd && step_ff < 4'd3 && !tim_ff) begin
               ctl.cmd = DC_BCD; step_in = step_ff + 4'd1;
               if (step_ff == 4'd2) tim_in = 1'b1;
            end else if (stat.is_store && !tim_ff) begin
               ctl.cmd = DC_STORE; step_in = step_ff + 4'd1;
               if (step_ff == stat.nx) tim_in = 1'b1;
            end else if (stat.is_load && !tim_ff) begin
               ctl.cmd = DC_LOAD; state_in = S_PIXWB;
            end else begin
               ctl.cmd = DC_TIMERS; ctl.step = 4'd0; state_in = S_DONE;
            end
         end
         S_DONE: begin rv_in = 1'b1; state_in = S_IDLE; end
         default: state_in = S_IDLE;
      endcase
      // load sweep: PIXWB slot writes register from memory read
      if (state_ff == S_PIXWB && stat.is_load && !stat.is_draw) begin
         ctl.cmd = DC_LOADWB; bit_in = bit_ff;
         step_in = step_ff + 4'd1;
         if (step_ff == stat.nx) tim_in = 1'b1;
         state_in = S_SEQ;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT; init_ff <= '0; step_ff <= '0; bit_ff <= '0;
         clr_ff <= '0; op_ff <= OP_WRITE; rv_ff <= 1'b0; tim_ff <= 1'b0;
      end else begin
         state_ff <= state_in; init_ff <= init_in; step_ff <= step_in; bit_ff <= bit_in;
         clr_ff <= clr_in; op_ff <= op_in; rv_ff <= rv_in; tim_ff <= tim_in;
      end
   end

   `C8_ASSERT_IMPL(a_start_idle, clock, reset, start && !busy, state_ff == S_IDLE)
   `C8_ASSERT_NEXT(a_done_valid, clock, reset, state_ff == S_DONE, rsp_valid)
   `C8_ASSERT_IMPL(a_valid_idle, clock, reset, rsp_valid, state_ff == S_IDLE)
endmodule
`default_nettype wire

// ----- rtl/chip8_instruction_core_top.sv -----
// Channel | handshake         | payload
// req     | start & !busy     | req_operation..req_random_byte
// rsp     | rsp_valid (1 cyc) | rsp_program_counter..rsp_pixel
// csr     | csr_write_enable  | csr_write_data (start address)
// Write and key requests go straight to the result; a pixel read reads the
// frame store; an execute fetches, executes, runs any sweep (00E0 frame sweep,
// DXYN sprite rows, FX33/FX55/FX65) and a timer step. A new request is taken at
// the edge that takes the result. After reset a pass over memory loads the font,
// zeroes the rest and clears the frame store while busy stays high. Results
// cannot be stalled. Depends on c8core_pkg, c8core_ctrl, c8core_datapath.
`default_nettype none
module chip8_instruction_core_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [11:0] req_address,
   input  wire logic [7:0]  req_data,
   input  wire logic [3:0]  req_key_index,
   input  wire logic        req_key_down,
   input  wire logic [7:0]  req_random_byte,
   input  wire logic        csr_write_enable,
   input  wire logic [11:0] csr_write_data,
   output logic             rsp_valid,
   output logic [11:0]      rsp_program_counter,
   output logic [15:0]      rsp_opcode,
   output logic             rsp_draw_flag,
   output logic             rsp_sound_beep,
   output logic             rsp_invalid_opcode,
   output logic             rsp_waiting_for_key,
   output logic             rsp_pixel
);
   import c8core_pkg::*;
   ctl_type  ctl;
   stat_type stat;
   logic init_busy;
   logic [11:0] init_addr;

   c8core_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_operation(req_operation),
      .stat(stat), .ctl(ctl), .busy(busy), .init_busy(init_busy),
      .init_addr(init_addr), .rsp_valid(rsp_valid));

   c8core_datapath u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .init_busy(init_busy),
      .init_addr(init_addr), .csr_we(csr_write_enable), .csr_data(csr_write_data),
      .req_operation(req_operation), .req_address(req_address), .req_data(req_data),
      .req_key_index(req_key_index), .req_key_down(req_key_down),
      .req_random_byte(req_random_byte), .stat(stat),
      .rsp_program_counter(rsp_program_counter), .rsp_opcode(rsp_opcode),
      .rsp_draw_flag(rsp_draw_flag), .rsp_sound_beep(rsp_sound_beep),
      .rsp_invalid_opcode(rsp_invalid_opcode), .rsp_waiting_for_key(rsp_waiting_for_key),
      .rsp_pixel(rsp_pixel));
endmodule
`default_nettype wire
